FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions on the clk / arst_n domain.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset
`define GPCM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked at every edge, reset included
`define GPCM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: sv/gpcm_pkg.sv
// ----------------------------------------------------------------------------
// gpcm_pkg
// Types and constants shared by the gradient palette color map.
// ----------------------------------------------------------------------------
`default_nettype none

package gpcm_pkg;

	localparam int COLOR_W    = 24;
	localparam int CHAN_W     = 8;
	localparam int NUM_CHAN   = 3;
	localparam int SEED_REGS  = 6;
	localparam int SEED_IDX_W = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int STEP_W     = 8;
	localparam int COUNT_W    = 16;
	localparam int SUM_W      = COUNT_W + STEP_W;
	localparam int PROD_W     = 16;

	typedef logic [COLOR_W-1:0] color_t;
	typedef color_t [SEED_REGS-1:0] seed_bank_t;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SEED_0     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ONSET_STEP = 3'd6;

	// Reset palette, seed 0 in the lowest slot
	localparam seed_bank_t SEED_RESET = {
		24'hEEEDF5, 24'hE3983B, 24'hD99650, 24'hE3983B, 24'hEEEDF5, 24'hEAB17A
	};
	localparam logic [STEP_W-1:0] STEP_RESET = 8'd0;

endpackage

`default_nettype wire

FILE: sv/gradient_palette_color_map.sv
// ----------------------------------------------------------------------------
// gradient_palette_color_map
// Maps an iteration count and an onset count to an RGB color from a
// ping-pong walked, linearly interpolated seed palette.
// ----------------------------------------------------------------------------
// Takes one word per clock while the output is not stalled and returns one
// color per word, in order. The nine-stage pipeline (index sum, two
// reciprocal multiplies and a fold for the modulo, segment split, seed
// select, blend multiply, reciprocal divide, apply) holds the words in
// flight; each stage stalls only when its successor is full and
// stalled, so bubbles are squeezed out. Seed and step registers are written
// through the cfg port and must only change while no word is in flight.
`default_nettype none
`include "assert_macros.svh"

module gradient_palette_color_map import gpcm_pkg::*; #(
	parameter int NUM_SEEDS         = 6,
	parameter int STEPS_PER_SEGMENT = 96
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// input stream
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [31:0]          s_axis_tdata,  // iteration_count, onset_count
	// output stream
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	output logic [23:0]               m_axis_tdata,  // red, green, blue
	// configuration writes
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [COLOR_W-1:0]   cfg_data
);

	localparam int IDX_W = $clog2(NUM_SEEDS * STEPS_PER_SEGMENT);

	seed_bank_t        seeds_q;
	logic [STEP_W-1:0] onset_step_q;

	logic             idx_valid, idx_ready;
	logic [IDX_W-1:0] idx;
	logic [CHAN_W-1:0] red, green, blue;

	// Configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seeds_q      <= SEED_RESET;
			onset_step_q <= STEP_RESET;
		end else if (cfg_valid) begin
			if (cfg_index < REG_ONSET_STEP)
				seeds_q[cfg_index - REG_SEED_0] <= cfg_data;
			else if (cfg_index == REG_ONSET_STEP)
				onset_step_q <= cfg_data[STEP_W-1:0];
		end
	end

	// Index front end
	gpcm_index #(
		.NUM_SEEDS        (NUM_SEEDS),
		.STEPS_PER_SEGMENT(STEPS_PER_SEGMENT),
		.IDX_W            (IDX_W)
	) u_index (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_axis_tvalid),
		.in_ready       (s_axis_tready),
		.iteration_count(s_axis_tdata[15:0]),
		.onset_count    (s_axis_tdata[31:16]),
		.onset_step     (onset_step_q),
		.out_valid      (idx_valid),
		.out_ready      (idx_ready),
		.out_idx        (idx)
	);

	// Blend back end
	gpcm_blend #(
		.NUM_SEEDS        (NUM_SEEDS),
		.STEPS_PER_SEGMENT(STEPS_PER_SEGMENT),
		.IDX_W            (IDX_W)
	) u_blend (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (idx_valid),
		.in_ready (idx_ready),
		.in_idx   (idx),
		.seeds    (seeds_q),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.red      (red),
		.green    (green),
		.blue     (blue)
	);

	assign m_axis_tdata = {blue, green, red};

	// Assertions
	`GPCM_ASSERT(a_stall_only_from_output, !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready), "input stalled while output free")
	`GPCM_ASSERT_ALWAYS(a_reset_empty, !arst_n |=> !m_axis_tvalid, "output word during reset")
	`GPCM_ASSERT(a_step_write, (cfg_valid && cfg_index == REG_ONSET_STEP) |=> (onset_step_q == $past(cfg_data[STEP_W-1:0])), "onset step write lost")

endmodule

`default_nettype wire

FILE: sv/gpcm_index.sv
// ----------------------------------------------------------------------------
// gpcm_index
// Four-stage front end: forms count + onsets * step, reduces it modulo the
// ping-pong period and folds the return half back onto the palette.
// ----------------------------------------------------------------------------
`default_nettype none

module gpcm_index import gpcm_pkg::*; #(
	parameter int NUM_SEEDS         = 6,
	parameter int STEPS_PER_SEGMENT = 96,
	parameter int IDX_W             = $clog2(NUM_SEEDS * STEPS_PER_SEGMENT)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [COUNT_W-1:0] iteration_count,
	input  wire logic [COUNT_W-1:0] onset_count,
	input  wire logic [STEP_W-1:0]  onset_step,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [IDX_W-1:0]        out_idx
);

	localparam int ONE_WAY  = NUM_SEEDS * STEPS_PER_SEGMENT;
	localparam int PERIOD   = 2 * ONE_WAY - 2;
	localparam int PER_W    = $clog2(PERIOD + 1);
	localparam int REM_W    = $clog2(2 * PERIOD);
	localparam longint RECIP = (longint'(1) << SUM_W) / PERIOD;
	localparam int RCP_W    = $clog2(RECIP + 1);
	localparam int MQ_W     = SUM_W + RCP_W;
	localparam int QP_W     = RCP_W + PER_W;

	localparam logic [RCP_W-1:0] RECIP_C  = RCP_W'(RECIP);
	localparam logic [PER_W-1:0] PERIOD_C = PER_W'(PERIOD);
	localparam logic [REM_W-1:0] PERIOD_R = REM_W'(PERIOD);
	localparam logic [REM_W-1:0] ONE_WAY_R = REM_W'(ONE_WAY);
	localparam logic [REM_W-1:0] MIRROR_R = REM_W'(2 * ONE_WAY - 1);

	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	logic [SUM_W-1:0] sum_s1, sum_s2, sum_s3;
	logic [MQ_W-1:0]  mq_s2;
	logic [SUM_W-1:0] qp_s3;
	logic [IDX_W-1:0] idx_s4;

	logic [COUNT_W+STEP_W-1:0] onset_prod;
	logic [QP_W-1:0]           qp_full;
	logic [SUM_W-1:0]          rem_full;
	logic [REM_W-1:0]          rem_raw, rem_fix, idx_fold;

	// Stage enables: a stage moves when it is empty or its successor moves
	assign en_s4    = !v_s4 || out_ready;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	// Stage 1: raw palette position
	assign onset_prod = onset_count * onset_step;

	// Stage 3: quotient estimate times period (estimate is low by at most one)
	assign qp_full = mq_s2[MQ_W-1 -: RCP_W] * PERIOD_C;

	// Stage 4: remainder with one correction, then mirror the return half
	always_comb begin
		rem_full = sum_s3 - qp_s3;
		rem_raw  = rem_full[REM_W-1:0];
		rem_fix  = (rem_raw >= PERIOD_R) ? rem_raw - PERIOD_R : rem_raw;
		idx_fold = (rem_fix >= ONE_WAY_R) ? MIRROR_R - rem_fix : rem_fix;
	end

	always_ff @(posedge clk) begin
		if (en_s1) sum_s1 <= SUM_W'(iteration_count) + SUM_W'(onset_prod);
		if (en_s2) begin
			sum_s2 <= sum_s1;
			mq_s2  <= sum_s1 * RECIP_C;
		end
		if (en_s3) begin
			sum_s3 <= sum_s2;
			qp_s3  <= qp_full[SUM_W-1:0];
		end
		if (en_s4) idx_s4 <= idx_fold[IDX_W-1:0];
	end

	assign out_valid = v_s4;
	assign out_idx   = idx_s4;

endmodule

`default_nettype wire

FILE: sv/gpcm_blend.sv
// ----------------------------------------------------------------------------
// gpcm_blend
// Five-stage back end: splits the palette index into segment and step, picks
// the two seeds and blends each channel with a truncating signed divide.
// ----------------------------------------------------------------------------
`default_nettype none

module gpcm_blend import gpcm_pkg::*; #(
	parameter int NUM_SEEDS         = 6,
	parameter int STEPS_PER_SEGMENT = 96,
	parameter int IDX_W             = $clog2(NUM_SEEDS * STEPS_PER_SEGMENT)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [IDX_W-1:0]  in_idx,
	input  wire seed_bank_t        seeds,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [CHAN_W-1:0]      red,
	output logic [CHAN_W-1:0]      green,
	output logic [CHAN_W-1:0]      blue
);

	localparam int SEG_W  = $clog2(NUM_SEEDS);
	localparam int K_W    = $clog2(STEPS_PER_SEGMENT);
	localparam int DIV_SH = PROD_W + K_W + 1;
	localparam longint RECIP =
		((longint'(1) << DIV_SH) + STEPS_PER_SEGMENT - 1) / STEPS_PER_SEGMENT;
	localparam int RCP_W  = $clog2(RECIP + 1);
	localparam int MUL_W  = PROD_W + RCP_W;

	localparam logic [RCP_W-1:0] RECIP_C  = RCP_W'(RECIP);
	localparam logic [SEG_W-1:0] LAST_SEG = SEG_W'(NUM_SEEDS - 1);

	logic v_s5, v_s6, v_s7, v_s8, v_s9;
	logic en_s5, en_s6, en_s7, en_s8, en_s9;

	logic [SEG_W-1:0] seg_s5;
	logic [K_W-1:0]   k_s5, k_s6;

	logic [NUM_CHAN-1:0][CHAN_W-1:0] ca_s6, ca_s7, ca_s8, chan_s9;
	logic [NUM_CHAN-1:0][CHAN_W-1:0] mag_s6;
	logic [NUM_CHAN-1:0]             neg_s6, neg_s7, neg_s8;
	logic [NUM_CHAN-1:0][PROD_W-1:0] prod_s7;
	logic [NUM_CHAN-1:0][MUL_W-1:0]  mq_s8;

	logic [SEG_W-1:0] seg_c, nxt_c;
	logic [IDX_W-1:0] base_c, k_diff;
	color_t           seed_a, seed_b;

	logic [NUM_CHAN-1:0][CHAN_W-1:0]     ca_c, cb_c, mag_c, quo_c, chan_c;
	logic [NUM_CHAN-1:0]                 neg_c;
	logic [NUM_CHAN-1:0][CHAN_W+K_W-1:0] prod_c;

	// Stage enables
	assign en_s9    = !v_s9 || out_ready;
	assign en_s8    = !v_s8 || en_s9;
	assign en_s7    = !v_s7 || en_s8;
	assign en_s6    = !v_s6 || en_s7;
	assign en_s5    = !v_s5 || en_s6;
	assign in_ready = en_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			if (en_s5) v_s5 <= in_valid;
			if (en_s6) v_s6 <= v_s5;
			if (en_s7) v_s7 <= v_s6;
			if (en_s8) v_s8 <= v_s7;
			if (en_s9) v_s9 <= v_s8;
		end
	end

	// Stage 5: segment by compare against segment starts, step as offset
	always_comb begin
		seg_c  = '0;
		base_c = '0;
		for (int j = 1; j < NUM_SEEDS; j++) begin
			if (in_idx >= IDX_W'(j * STEPS_PER_SEGMENT)) begin
				seg_c  = SEG_W'(j);
				base_c = IDX_W'(j * STEPS_PER_SEGMENT);
			end
		end
		k_diff = in_idx - base_c;
	end

	// Stage 6: seed pair, per-channel sign and magnitude of the difference
	always_comb begin
		nxt_c  = (seg_s5 == LAST_SEG) ? '0 : seg_s5 + 1'b1;
		seed_a = seeds[SEED_IDX_W'(seg_s5)];
		seed_b = seeds[SEED_IDX_W'(nxt_c)];
		for (int c = 0; c < NUM_CHAN; c++) begin
			ca_c[c]  = seed_a[(NUM_CHAN-1-c)*CHAN_W +: CHAN_W];
			cb_c[c]  = seed_b[(NUM_CHAN-1-c)*CHAN_W +: CHAN_W];
			neg_c[c] = cb_c[c] < ca_c[c];
			mag_c[c] = neg_c[c] ? ca_c[c] - cb_c[c] : cb_c[c] - ca_c[c];
		end
	end

	// Stage 7 product, stage 9 reciprocal quotient and signed apply
	always_comb begin
		for (int c = 0; c < NUM_CHAN; c++) begin
			prod_c[c] = mag_s6[c] * k_s6;
			quo_c[c]  = mq_s8[c][DIV_SH +: CHAN_W];
			chan_c[c] = neg_s8[c] ? ca_s8[c] - quo_c[c] : ca_s8[c] + quo_c[c];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			seg_s5 <= seg_c;
			k_s5   <= k_diff[K_W-1:0];
		end
		if (en_s6) begin
			k_s6   <= k_s5;
			ca_s6  <= ca_c;
			mag_s6 <= mag_c;
			neg_s6 <= neg_c;
		end
		if (en_s7) begin
			ca_s7  <= ca_s6;
			neg_s7 <= neg_s6;
			for (int c = 0; c < NUM_CHAN; c++)
				prod_s7[c] <= PROD_W'(prod_c[c]);
		end
		if (en_s8) begin
			ca_s8  <= ca_s7;
			neg_s8 <= neg_s7;
			for (int c = 0; c < NUM_CHAN; c++)
				mq_s8[c] <= prod_s7[c] * RECIP_C;
		end
		if (en_s9) chan_s9 <= chan_c;
	end

	assign out_valid = v_s9;
	assign red       = chan_s9[0];
	assign green     = chan_s9[1];
	assign blue      = chan_s9[2];

endmodule

`default_nettype wire

FILE: bench/gpcm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpcm_checker
// Watches the stream and config channels of the gradient palette color map,
// keeps its own copy of the palette registers, predicts the color of every
// accepted input word and compares each output word with the oldest
// prediction.
// ----------------------------------------------------------------------------
module gpcm_checker import gpcm_pkg::*; #(
	parameter int NUM_SEEDS         = 6,
	parameter int STEPS_PER_SEGMENT = 96
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	input  wire logic                 s_axis_tready,
	input  wire logic [31:0]          s_axis_tdata,  // iteration_count, onset_count
	input  wire logic                 m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	input  wire logic [23:0]          m_axis_tdata,  // red, green, blue
	input  wire logic                 cfg_valid,
	input  wire logic                 cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [COLOR_W-1:0]   cfg_data,
	output int                        mismatches,
	output int                        pending
);

	localparam int ONE_WAY = NUM_SEEDS * STEPS_PER_SEGMENT;
	localparam int PERIOD  = 2 * ONE_WAY - 2;

	// red in the low byte, as on the output bus
	typedef struct packed {
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] red;
	} rgb_t;

	color_t            seed_q [SEED_REGS];
	logic [STEP_W-1:0] step_q;
	rgb_t              expected_colors [$];

	// Ping-pong palette position, then linear blend toward the next seed
	function automatic rgb_t palette_color(input logic [COUNT_W-1:0] iter_cnt,
			input logic [COUNT_W-1:0] onsets);
		int unsigned pos;
		int          seg, k, nxt, lo, hi, mix;
		rgb_t        c;
		pos = (32'(iter_cnt) + 32'(onsets) * 32'(step_q)) % PERIOD;
		if (pos >= ONE_WAY)
			pos = 2 * ONE_WAY - 1 - pos;
		seg = pos / STEPS_PER_SEGMENT;
		k   = pos % STEPS_PER_SEGMENT;
		nxt = (seg == NUM_SEEDS - 1) ? 0 : seg + 1;
		for (int ch = 0; ch < NUM_CHAN; ch++) begin
			lo  = seed_q[seg][16 - 8 * ch +: 8];
			hi  = seed_q[nxt][16 - 8 * ch +: 8];
			// signed divide, truncates toward zero
			mix = lo + ((hi - lo) * k) / STEPS_PER_SEGMENT;
			c[8 * ch +: 8] = mix[7:0];
		end
		return c;
	endfunction

	task automatic report_mismatch(input string what, input logic [23:0] got,
			input logic [23:0] want);
		$display("%0t: color word mismatch on %s: got %06h, want %06h", $time, what, got,
			want);
		mismatches++;
	endtask

	// Track config, queue predictions, compare output words
	always @(posedge clk or negedge arst_n) begin
		rgb_t got, want;
		if (!arst_n) begin
			for (int i = 0; i < SEED_REGS; i++)
				seed_q[i] = SEED_RESET[i];
			step_q = STEP_RESET;
			expected_colors.delete();
			mismatches = 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index < SEED_REGS)
					seed_q[cfg_index - REG_SEED_0] = cfg_data;
				else if (cfg_index == REG_ONSET_STEP)
					step_q = cfg_data[STEP_W-1:0];
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_colors.insert(expected_colors.size(),
					palette_color(s_axis_tdata[15:0], s_axis_tdata[31:16]));
			if (m_axis_tvalid && m_axis_tready) begin
				got = rgb_t'(m_axis_tdata);
				if (expected_colors.size() == 0) begin
					report_mismatch("unexpected word", got, '0);
				end else begin
					want = expected_colors.pop_front();
					if (got.red !== want.red)
						report_mismatch("red", 24'(got.red), 24'(want.red));
					if (got.green !== want.green)
						report_mismatch("green", 24'(got.green), 24'(want.green));
					if (got.blue !== want.blue)
						report_mismatch("blue", 24'(got.blue), 24'(want.blue));
				end
			end
			pending <= expected_colors.size();
		end
	end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the gradient palette color map: directed words at the palette
// edges, then random words under several palette settings, with bursty input,
// a stalling output and one long output hold-off. The checker does the
// prediction and comparison.
// ----------------------------------------------------------------------------
module tb_top;
	import gpcm_pkg::*;

	localparam int NUM_SEEDS         = 6;
	localparam int STEPS_PER_SEGMENT = 96;
	localparam int CYCLE_LIMIT       = 200000;
	localparam int DRAIN_CYCLES      = 16;
	localparam int HOLD_CYCLES       = 100;
	localparam int PHASE_WORDS       = 180;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [31:0]          s_axis_tdata  = '0;  // iteration_count, onset_count
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b1;
	logic [23:0]          m_axis_tdata;        // red, green, blue
	logic                 cfg_valid     = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index     = '0;
	logic [COLOR_W-1:0]   cfg_data      = '0;

	int mismatches;
	int pending;
	int cycles     = 0;
	int burst_left = 0;
	bit no_gaps    = 1'b0;
	bit hold_req   = 1'b0;

	always #6 clk = ~clk;

	gradient_palette_color_map #(
		.NUM_SEEDS(NUM_SEEDS),
		.STEPS_PER_SEGMENT(STEPS_PER_SEGMENT)
	) u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	gpcm_checker #(
		.NUM_SEEDS(NUM_SEEDS),
		.STEPS_PER_SEGMENT(STEPS_PER_SEGMENT)
	) u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .pending(pending)
	);

	// Run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Output side: stall pattern changes mode every span, one long hold-off
	initial begin
		int mode;
		int span;
		bit hold_done;
		hold_done = 1'b0;
		forever begin
			mode = $urandom_range(0, 2);
			span = $urandom_range(10, 150);
			repeat (span) begin
				@(posedge clk);
				if (hold_req && !hold_done) begin
					hold_done = 1'b1;
					m_axis_tready <= 1'b0;
					repeat (HOLD_CYCLES) @(posedge clk);
				end
				case (mode)
					0: begin
						m_axis_tready <= 1'b1;
					end
					1: begin
						m_axis_tready <= 1'($urandom_range(0, 1));
					end
					default: begin
						m_axis_tready <= ($urandom_range(0, 3) == 0);
					end
				endcase
			end
		end
	end

	// Input word, sent in bursts with random gaps between them
	task automatic send_word(input logic [COUNT_W-1:0] iter_cnt,
			input logic [COUNT_W-1:0] onsets);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = no_gaps ? 0 : $urandom_range(0, 6);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tdata  <= {onsets, iter_cnt};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Stop sending and wait until every color word is back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// cfg_valid stays high across back-to-back writes; caller lowers it
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input color_t val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_palette(input color_t s0, s1, s2, s3, s4, s5,
			input logic [STEP_W-1:0] onset_step);
		color_t step_word;
		step_word = color_t'($urandom);
		step_word[STEP_W-1:0] = onset_step;
		drain();
		write_reg(REG_SEED_0 + 3'd0, s0);
		write_reg(REG_SEED_0 + 3'd1, s1);
		write_reg(REG_SEED_0 + 3'd2, s2);
		write_reg(REG_SEED_0 + 3'd3, s3);
		write_reg(REG_SEED_0 + 3'd4, s4);
		write_reg(REG_SEED_0 + 3'd5, s5);
		write_reg(REG_ONSET_STEP, step_word);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Random word: mostly full range, some near the palette fold and wrap points
	function automatic logic [31:0] pick_word();
		int sel;
		logic [COUNT_W-1:0] c, o;
		sel = $urandom_range(0, 19);
		if (sel < 12) begin
			c = COUNT_W'($urandom);
			o = COUNT_W'($urandom);
		end else if (sel < 16) begin
			c = COUNT_W'($urandom_range(0, 2400));
			o = COUNT_W'($urandom_range(0, 15));
		end else if (sel < 18) begin
			c = COUNT_W'(96 * $urandom_range(1, 24) - $urandom_range(0, 1));
			o = '0;
		end else begin
			c = COUNT_W'(1150 * $urandom_range(1, 56) - $urandom_range(0, 1));
			o = '0;
		end
		return {o, c};
	endfunction

	initial begin
		logic [31:0] w;
		logic [STEP_W-1:0] step_pick;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset palette, onset step zero: segment edges, fold and wrap points
		send_word(16'd0, 16'd0);
		send_word(16'd95, 16'hFFFF);
		send_word(16'd96, 16'd0);
		send_word(16'd479, 16'd0);
		send_word(16'd575, 16'd0);
		send_word(16'd576, 16'd0);
		send_word(16'd1149, 16'd0);
		send_word(16'd1150, 16'd0);
		send_word(16'hFFFF, 16'd0);
		send_word(16'd0, 16'hFFFF);

		// Extreme seeds, largest step: full-swing blends both ways, max index sum
		load_palette(24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'hFF00FF,
			24'h00FF00, 8'd255);
		drain();
		write_reg(REG_UNUSED, color_t'($urandom));
		cfg_valid <= 1'b0;
		@(posedge clk);
		send_word(16'hFFFF, 16'hFFFF);
		send_word(16'd1, 16'd0);
		send_word(16'd95, 16'd0);
		send_word(16'd191, 16'd0);
		send_word(16'd287, 16'd0);
		send_word(16'd574, 16'd0);
		send_word(16'd575, 16'd0);
		send_word(16'd0, 16'd1);
		send_word(16'd0, 16'd4);
		send_word(16'd1, 16'd4);

		// Random phases, each with its own palette and onset step
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: step_pick = 8'd1;
				1: step_pick = 8'd255;
				3: step_pick = 8'd0;
				5: step_pick = 8'd128;
				default: step_pick = STEP_W'($urandom);
			endcase
			load_palette(color_t'($urandom), color_t'($urandom), color_t'($urandom),
				color_t'($urandom), color_t'($urandom), color_t'($urandom), step_pick);
			// back-to-back words into a held-off output
			if (ph == 2) begin
				hold_req <= 1'b1;
				no_gaps = 1'b1;
			end
			repeat (PHASE_WORDS) begin
				w = pick_word();
				send_word(w[15:0], w[31:16]);
			end
			no_gaps = 1'b0;
		end

		drain();
		if (mismatches == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
